/* sv/jscn_pkg.sv */
// Shared constants and types for the joystick sample calibrate/normalize block.
// Used by the channel interfaces and the top level; depends on nothing.
package jscn_pkg;

  localparam int SampleW = 12;
  localparam int ByteW   = 8;
  localparam int ProdW   = 2 * SampleW;
  localparam int CntW    = $clog2(SampleW);

  localparam int                FailW     = 3;
  localparam logic [FailW-1:0]  FailSat   = 3'd7;
  localparam logic [FailW-1:0]  SlowLevel = 3'd5;

  localparam int                  CfgIdxW    = 2;
  localparam int                  CfgDataW   = SampleW;
  localparam logic [CfgIdxW-1:0]  CfgAxisMin = 2'd0;
  localparam logic [CfgIdxW-1:0]  CfgAxisMax = 2'd1;
  localparam logic [CfgIdxW-1:0]  CfgCalEn   = 2'd2;

  typedef logic [SampleW-1:0] sample_t;
  typedef logic [ByteW-1:0]   byte_t;

endpackage

/* sv/jscn_in_if.sv */
// Input channel: one poll result (flag plus four received bytes) with valid/ready.
// Depends on jscn_pkg.
interface jscn_in_if import jscn_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  read_ok;
  byte_t y_high_byte;
  byte_t y_low_byte;
  byte_t x_high_byte;
  byte_t x_low_byte;

  modport source (output valid, read_ok, y_high_byte, y_low_byte, x_high_byte, x_low_byte,
                  input ready);
  modport sink   (input valid, read_ok, y_high_byte, y_low_byte, x_high_byte, x_low_byte,
                  output ready);
endinterface

/* sv/jscn_out_if.sv */
// Result channel: normalized position and poll status with valid/ready.
// Depends on jscn_pkg.
interface jscn_out_if import jscn_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    event_valid;
  sample_t x_out;
  sample_t y_out;
  logic    slow_poll;

  modport source (output valid, event_valid, x_out, y_out, slow_poll, input ready);
  modport sink   (input valid, event_valid, x_out, y_out, slow_poll, output ready);
endinterface

/* sv/joystick_sample_calibrate_normalise_unit.sv */
// Joystick sample calibration and normalization, top level.
// Depends on jscn_pkg, jscn_in_if and jscn_out_if.
//
// Each accepted item is one poll result: a success flag and four bytes (Y high,
// Y low, X high, X low). A good read unpacks 12-bit Y and X, clamps each to
// [axis_min, axis_max] and maps it piecewise-linearly so that the rest center
// lands on (axis_min + axis_max) / 2 while the limits map to themselves. With
// calibrate_enable armed, the first good sample becomes the rest center; any
// write to calibrate_enable drops a captured center. A center at or beyond a
// limit passes through as the axis result. A failed read returns a zero
// position with event_valid low; consecutive failures are counted (saturating
// at 7) and slow_poll is raised from five on. Exactly one result per item.
// Steps: a failed read goes from accept straight to the done state and the
// output register. A good read runs setup, multiply and 12 divide steps for
// X and then for Y; an axis whose center sits on a limit skips its multiply
// and divide. One shared multiply and 12-step restoring divider serve X and
// then Y. The input is not ready while an item is in work; the output register
// lets the next item in while a result still waits.
module joystick_sample_calibrate_normalise_unit import jscn_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  jscn_in_if.sink             in_s,
  jscn_out_if.source          out_s,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t     state_r;

  // configuration
  sample_t    axis_min_r;
  sample_t    axis_max_r;
  logic       cal_en_r;

  // persistent state
  logic       captured_r;
  sample_t    center_x_r;
  sample_t    center_y_r;
  logic [FailW-1:0] fail_cnt_r;

  // per-item working registers
  logic       ok_r;
  logic       slow_r;
  sample_t    samp_x_r;
  sample_t    samp_y_r;
  logic       ax_sel_r;     // 0: X in work, 1: Y in work
  sample_t    op_a_r;
  sample_t    op_b_r;
  sample_t    den_r;
  sample_t    base_r;
  sample_t    num_r;        // low half of the dividend, shifted out MSB first
  sample_t    rem_r;
  sample_t    quo_r;
  logic [CntW-1:0] cnt_r;
  sample_t    res_x_r;
  sample_t    res_y_r;

  // output register
  logic       out_valid_r;
  logic       out_ok_r;
  sample_t    out_x_r;
  sample_t    out_y_r;
  logic       out_slow_r;

  logic                  in_acc;
  logic [2*ByteW-1:0]    raw_x;
  logic [2*ByteW-1:0]    raw_y;
  logic [FailW-1:0]      fail_nxt;
  logic [SampleW:0]      lim_sum;
  sample_t               mid;
  sample_t               v_sel;
  sample_t               c_sel;
  sample_t               v_clamp;
  logic                  at_limit;
  logic                  upper;
  logic [ProdW-1:0]      prod;
  logic [SampleW:0]      trial;
  logic                  fits;
  logic [SampleW:0]      trial_sub;
  sample_t               rem_step;
  sample_t               quo_step;
  sample_t               div_res;
  logic                  fin_valid;
  sample_t               fin_val;
  logic                  out_free;

  assign in_s.ready        = (state_r == ST_IDLE);
  assign in_acc            = in_s.valid && in_s.ready;

  assign out_s.valid       = out_valid_r;
  assign out_s.event_valid = out_ok_r;
  assign out_s.x_out       = out_x_r;
  assign out_s.y_out       = out_y_r;
  assign out_s.slow_poll   = out_slow_r;

  assign out_free = !out_valid_r || out_s.ready;

  // unpack: high byte then low byte, keep the sample bits
  assign raw_y = {in_s.y_high_byte, in_s.y_low_byte};
  assign raw_x = {in_s.x_high_byte, in_s.x_low_byte};

  always_comb begin
    if (in_s.read_ok) begin
      fail_nxt = '0;
    end else if (fail_cnt_r < FailSat) begin
      fail_nxt = fail_cnt_r + FailW'(1);
    end else begin
      fail_nxt = fail_cnt_r;
    end
  end

  // midpoint of the limits, also the target for the rest center
  assign lim_sum = {1'b0, axis_min_r} + {1'b0, axis_max_r};
  assign mid     = lim_sum[SampleW:1];

  // operand selection for the axis in work
  assign v_sel    = ax_sel_r ? samp_y_r : samp_x_r;
  assign c_sel    = captured_r ? (ax_sel_r ? center_y_r : center_x_r) : mid;
  assign at_limit = (c_sel <= axis_min_r) || (c_sel >= axis_max_r);

  always_comb begin
    if (v_sel > axis_max_r) begin
      v_clamp = axis_max_r;
    end else if (v_sel < axis_min_r) begin
      v_clamp = axis_min_r;
    end else begin
      v_clamp = v_sel;
    end
  end

  assign upper = v_clamp > c_sel;

  // shared multiplier
  assign prod = ProdW'(op_a_r) * ProdW'(op_b_r);

  // one restoring divide step; the quotient always fits in SampleW bits
  assign trial     = {rem_r, num_r[SampleW-1]};
  assign fits      = trial >= {1'b0, den_r};
  assign trial_sub = trial - {1'b0, den_r};
  assign rem_step  = fits ? trial_sub[SampleW-1:0] : trial[SampleW-1:0];
  assign quo_step  = {quo_r[SampleW-2:0], fits};
  assign div_res   = base_r + quo_step;

  // an axis result is ready: center on a limit, or last divide step
  assign fin_valid = ((state_r == ST_SETUP) && at_limit) ||
                     ((state_r == ST_DIV) && (cnt_r == '0));
  assign fin_val   = (state_r == ST_SETUP) ? c_sel : div_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      axis_min_r  <= '0;
      axis_max_r  <= '1;
      cal_en_r    <= 1'b0;
      captured_r  <= 1'b0;
      center_x_r  <= '0;
      center_y_r  <= '0;
      fail_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // configuration: writes must arrive only while idle; the block does not enforce it
      if (cfg_we) begin
        case (cfg_idx)
          CfgAxisMin: axis_min_r <= cfg_wdata[SampleW-1:0];
          CfgAxisMax: axis_max_r <= cfg_wdata[SampleW-1:0];
          CfgCalEn: begin
            cal_en_r   <= cfg_wdata[0];
            captured_r <= 1'b0;
          end
          default: ;
        endcase
      end

      // drop the held result once taken, unless a new one loads below
      if (out_s.ready && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            ok_r       <= in_s.read_ok;
            fail_cnt_r <= fail_nxt;
            slow_r     <= (fail_nxt >= SlowLevel);
            ax_sel_r   <= 1'b0;
            if (in_s.read_ok) begin
              samp_x_r <= raw_x[SampleW-1:0];
              samp_y_r <= raw_y[SampleW-1:0];
              if (cal_en_r && !captured_r) begin
                center_x_r <= raw_x[SampleW-1:0];
                center_y_r <= raw_y[SampleW-1:0];
                captured_r <= 1'b1;
              end
              state_r <= ST_SETUP;
            end else begin
              res_x_r <= '0;
              res_y_r <= '0;
              state_r <= ST_DONE;
            end
          end
        end
        ST_SETUP: begin
          // pick the segment: above center scales into [mid, max], else [min, mid]
          if (!at_limit) begin
            if (upper) begin
              op_a_r <= v_clamp - c_sel;
              op_b_r <= axis_max_r - mid;
              den_r  <= axis_max_r - c_sel;
              base_r <= mid;
            end else begin
              op_a_r <= v_clamp - axis_min_r;
              op_b_r <= mid - axis_min_r;
              den_r  <= c_sel - axis_min_r;
              base_r <= axis_min_r;
            end
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          rem_r   <= prod[ProdW-1:SampleW];
          num_r   <= prod[SampleW-1:0];
          quo_r   <= '0;
          cnt_r   <= CntW'(SampleW - 1);
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          rem_r <= rem_step;
          num_r <= {num_r[SampleW-2:0], 1'b0};
          quo_r <= quo_step;
          cnt_r <= cnt_r - CntW'(1);
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_ok_r    <= ok_r;
            out_x_r     <= res_x_r;
            out_y_r     <= res_y_r;
            out_slow_r  <= slow_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      // store the axis result, then advance to Y or finish
      if (fin_valid) begin
        if (!ax_sel_r) begin
          res_x_r  <= fin_val;
          ax_sel_r <= 1'b1;
          state_r  <= ST_SETUP;
        end else begin
          res_y_r <= fin_val;
          state_r <= ST_DONE;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_fail_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_s.read_ok) |=>
      (($past(fail_cnt_r) == FailSat) ? (fail_cnt_r == FailSat)
                                      : (fail_cnt_r == $past(fail_cnt_r) + FailW'(1))))
    else $error("failure count did not step or saturate");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < den_r))
    else $error("partial remainder not below divisor");

  a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DIV) && fin_valid) |-> (div_res <= axis_max_r))
    else $error("scaled result above axis_max");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> ((out_x_r == '0) && (out_y_r == '0)))
    else $error("failed read carries a nonzero position");

  a_capture: assert property (@(posedge clk) disable iff (!rst_n)
    captured_r |-> cal_en_r)
    else $error("center captured while calibration disarmed");
`endif

endmodule

/* test/testbench.sv */
// Self-checking testbench for joystick_sample_calibrate_normalise_unit.
// Needs jscn_pkg, jscn_in_if, jscn_out_if and the top-level RTL; it models the
// block itself and compares every result it produces, in order.
module testbench;
  import jscn_pkg::*;

  // Index 3 decodes to no register; writes to it must leave the block alone.
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

  localparam int unsigned RunLimit  = 2_000_000;  // time units, far past a clean run
  localparam int unsigned LongHold  = 300;        // cycles the receiver holds off once
  localparam int unsigned Settle    = 32;         // cycles let pass after a drain
  localparam int unsigned RandPhases = 8;
  localparam int unsigned PhaseItems = 60;

  typedef struct packed {
    logic  read_ok;
    byte_t y_hi;
    byte_t y_lo;
    byte_t x_hi;
    byte_t x_lo;
  } poll_t;

  typedef struct packed {
    logic    event_valid;
    sample_t x_pos;
    sample_t y_pos;
    logic    slow_poll;
  } pos_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  jscn_in_if  in_if ();
  jscn_out_if out_if ();

  joystick_sample_calibrate_normalise_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (in_if),
    .out_s     (out_if),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the block: limits, calibration arm, captured center, failure run.
  sample_t          lim_lo;
  sample_t          lim_hi;
  logic             cal_armed;
  sample_t          rest_x;
  sample_t          rest_y;
  logic             rest_held;
  logic [FailW-1:0] fail_run;

  poll_t poll_q[$];      // polls waiting to be offered
  pos_t  position_q[$];  // predicted results, oldest first
  pos_t  want_pos;

  int unsigned n_err;
  int unsigned n_good;
  int unsigned n_bad;
  int unsigned n_slow;
  int unsigned n_capture;
  int unsigned n_wr;

  bit          gaps_on;
  bit          hold_req;
  int unsigned src_gap;
  int unsigned snk_gap;
  int unsigned hold_left;

  // Map one clamped axis sample so the rest center lands on the midpoint of the
  // limits while the limits map to themselves; a center on or past a limit
  // passes straight through.
  function automatic sample_t map_axis(sample_t v, sample_t lo, sample_t ctr, sample_t hi);
    int unsigned lo_w, hi_w, ctr_w, ideal, val, num;
    lo_w  = 32'(lo);
    hi_w  = 32'(hi);
    ctr_w = 32'(ctr);
    ideal = (lo_w + hi_w) / 2;
    val   = 32'(v);
    if (ctr_w <= lo_w || ctr_w >= hi_w) return ctr;
    if (val > hi_w) val = hi_w;
    if (val < lo_w) val = lo_w;
    if (val > ctr_w) begin
      num = (val - ctr_w) * (hi_w - ideal);
      return sample_t'(ideal + num / (hi_w - ctr_w));
    end
    num = (val - lo_w) * (ideal - lo_w);
    return sample_t'(lo_w + num / (ctr_w - lo_w));
  endfunction

  // Advance the shadow by one accepted poll and queue the result it must give.
  function automatic void predict_position(poll_t p);
    pos_t                 r;
    logic [2*ByteW-1:0]   y_raw, x_raw;
    sample_t              xs, ys, cx, cy, mid;
    int unsigned          sum;
    r = '0;
    if (p.read_ok) begin
      y_raw    = {p.y_hi, p.y_lo};
      x_raw    = {p.x_hi, p.x_lo};
      ys       = y_raw[SampleW-1:0];
      xs       = x_raw[SampleW-1:0];
      fail_run = '0;
      if (cal_armed && !rest_held) begin
        rest_x    = xs;
        rest_y    = ys;
        rest_held = 1'b1;
        n_capture++;
      end
      sum = 32'(lim_lo);
      sum = (sum + 32'(lim_hi)) / 2;
      mid = sample_t'(sum);
      cx  = rest_held ? rest_x : mid;
      cy  = rest_held ? rest_y : mid;
      r.event_valid = 1'b1;
      r.x_pos       = map_axis(xs, lim_lo, cx, lim_hi);
      r.y_pos       = map_axis(ys, lim_lo, cy, lim_hi);
    end else if (fail_run < FailSat) begin
      fail_run++;
    end
    r.slow_poll = (fail_run >= SlowLevel);
    position_q.push_back(r);
  endfunction

  function automatic poll_t mk_poll(logic ok, logic [15:0] y, logic [15:0] x);
    return '{read_ok: ok, y_hi: y[15:8], y_lo: y[7:0], x_hi: x[15:8], x_lo: x[7:0]};
  endfunction

  // Random axis word: junk in the upper nibble, and the sample either anywhere
  // or clustered around a limit or the midpoint where the mapping bends.
  function automatic logic [15:0] pick_axis(sample_t lo, sample_t hi);
    sample_t    v;
    logic [3:0] junk;
    junk = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 3))
      0:       v = sample_t'($urandom_range(0, 4095));
      1:       v = sample_t'(32'(lo) + $urandom_range(0, 8) - 4);
      2:       v = sample_t'(32'(hi) + $urandom_range(0, 8) - 4);
      default: v = sample_t'((32'(lo) + 32'(hi)) / 2 + $urandom_range(0, 16) - 8);
    endcase
    return {junk, v};
  endfunction

  // Write one register and mirror it in the shadow; call only while idle.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    n_wr++;
    case (idx)
      CfgAxisMin: lim_lo = val;
      CfgAxisMax: lim_hi = val;
      CfgCalEn: begin
        cal_armed = val[0];
        rest_held = 1'b0;
      end
      default: ;
    endcase
  endtask

  // Hold until every queued poll is taken and every result is back, then
  // let the block settle.
  task automatic wait_idle();
    do @(negedge clk); while (poll_q.size() != 0 || position_q.size() != 0);
    repeat (Settle) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Drive every input to a known level before the first edge.
  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = CfgAxisMin;
    cfg_wdata         = '0;
    in_if.valid       = 1'b0;
    in_if.read_ok     = 1'b0;
    in_if.y_high_byte = '0;
    in_if.y_low_byte  = '0;
    in_if.x_high_byte = '0;
    in_if.x_low_byte  = '0;
    out_if.ready      = 1'b0;
  end

  initial begin
    #(RunLimit);
    $display("DONE: errors detected");
    $finish;
  end

  // Driver: offer the oldest pending poll, keep it steady until taken, and
  // drop valid for short random bursts after a hand-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_position(poll_q.pop_front());
        if (gaps_on && $urandom_range(0, 3) == 0) src_gap = $urandom_range(1, 6);
      end
      // Leave an offered item untouched until the block takes it.
      if (!(in_if.valid && !in_if.ready)) begin
        if (src_gap > 0) begin
          src_gap--;
          in_if.valid <= 1'b0;
        end else if (poll_q.size() > 0) begin
          in_if.valid       <= 1'b1;
          in_if.read_ok     <= poll_q[0].read_ok;
          in_if.y_high_byte <= poll_q[0].y_hi;
          in_if.y_low_byte  <= poll_q[0].y_lo;
          in_if.x_high_byte <= poll_q[0].x_hi;
          in_if.x_low_byte  <= poll_q[0].x_lo;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result taken against the oldest prediction, then pick
  // the next ready level: a long hold-off when asked, else random bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      snk_gap   = 0;
      hold_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (position_q.size() == 0) begin
          $error("result with no prediction waiting: event_valid %0d x_out %0d y_out %0d",
                 out_if.event_valid, out_if.x_out, out_if.y_out);
          n_err++;
        end else begin
          want_pos = position_q.pop_front();
          if (out_if.event_valid !== want_pos.event_valid) begin
            $error("event_valid: expected %0d, got %0d", want_pos.event_valid,
                   out_if.event_valid);
            n_err++;
          end
          if (out_if.x_out !== want_pos.x_pos) begin
            $error("x_out: expected %0d, got %0d", want_pos.x_pos, out_if.x_out);
            n_err++;
          end
          if (out_if.y_out !== want_pos.y_pos) begin
            $error("y_out: expected %0d, got %0d", want_pos.y_pos, out_if.y_out);
            n_err++;
          end
          if (out_if.slow_poll !== want_pos.slow_poll) begin
            $error("slow_poll: expected %0d, got %0d", want_pos.slow_poll,
                   out_if.slow_poll);
            n_err++;
          end
        end
        if (out_if.event_valid === 1'b1) n_good++;
        else n_bad++;
        if (out_if.slow_poll === 1'b1) n_slow++;
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (gaps_on && $urandom_range(0, 4) == 0) snk_gap = $urandom_range(1, 6);
      end
    end
  end

  initial begin : stimulus
    int unsigned ph, i, fail_left;
    sample_t     lo, hi;
    logic        ok;

    lim_lo    = '0;
    lim_hi    = 12'hFFF;
    cal_armed = 1'b0;
    rest_x    = '0;
    rest_y    = '0;
    rest_held = 1'b0;
    fail_run  = '0;
    n_err     = 0;
    n_good    = 0;
    n_bad     = 0;
    n_slow    = 0;
    n_capture = 0;
    n_wr      = 0;
    gaps_on   = 1'b1;
    hold_req  = 1'b0;
    fail_left = 0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset limits: bottom and top words, junk in the upper nibbles, then a
    // failure run long enough to raise slow_poll and saturate, cleared by a
    // good read, then one failure carrying nonzero bytes.
    @(negedge clk);
    poll_q.push_back(mk_poll(1'b1, 16'h0000, 16'h0000));
    poll_q.push_back(mk_poll(1'b1, 16'hFFFF, 16'hFFFF));
    poll_q.push_back(mk_poll(1'b1, 16'hF800, 16'h07FF));
    repeat (8) poll_q.push_back(mk_poll(1'b0, 16'h0000, 16'h0000));
    poll_q.push_back(mk_poll(1'b1, 16'h5A5A, 16'hA5A5));
    poll_q.push_back(mk_poll(1'b0, 16'hFFFF, 16'hFFFF));
    wait_idle();

    // Arm calibration: a failure must not capture, the next good sample does,
    // and later samples (clamped at both ends) bend around that center.
    write_reg(CfgAxisMin, 12'd100);
    write_reg(CfgAxisMax, 12'd3900);
    write_reg(CfgCalEn, 12'd1);
    @(negedge clk);
    poll_q.push_back(mk_poll(1'b0, 16'h0BB8, 16'h03E8));
    poll_q.push_back(mk_poll(1'b1, 16'd3000, 16'd1000));
    poll_q.push_back(mk_poll(1'b1, 16'h0000, 16'h0000));
    poll_q.push_back(mk_poll(1'b1, 16'hFFFF, 16'hFFFF));
    poll_q.push_back(mk_poll(1'b1, 16'd1000, 16'd3000));
    wait_idle();

    // Disarm with upper data bits set (ignored), then re-arm and capture a
    // center sitting exactly on each limit.
    write_reg(CfgCalEn, 12'hFFE);
    @(negedge clk);
    poll_q.push_back(mk_poll(1'b1, 16'd3000, 16'd1000));
    poll_q.push_back(mk_poll(1'b1, 16'd2000, 16'd2001));
    wait_idle();
    write_reg(CfgCalEn, 12'hFFF);
    @(negedge clk);
    poll_q.push_back(mk_poll(1'b1, 16'd3900, 16'd100));
    poll_q.push_back(mk_poll(1'b1, 16'd50, 16'd3000));
    wait_idle();

    // Inverted and equal limits pass the midpoint through; a write to the
    // spare index must change nothing.
    write_reg(CfgCalEn, 12'd0);
    write_reg(CfgAxisMin, 12'd3000);
    write_reg(CfgAxisMax, 12'd1000);
    @(negedge clk);
    poll_q.push_back(mk_poll(1'b1, 16'd0, 16'd4095));
    poll_q.push_back(mk_poll(1'b1, 16'd2000, 16'd2500));
    wait_idle();
    write_reg(CfgAxisMin, 12'd2000);
    write_reg(CfgAxisMax, 12'd2000);
    @(negedge clk);
    poll_q.push_back(mk_poll(1'b1, 16'd1999, 16'd2001));
    wait_idle();
    write_reg(CfgSpare, 12'hABC);
    @(negedge clk);
    poll_q.push_back(mk_poll(1'b1, 16'h1234, 16'h0FED));
    wait_idle();

    // Random phases: fresh limits each time, calibration re-armed or dropped at
    // random, mostly good reads with bursts of failures.
    for (ph = 0; ph < RandPhases; ph++) begin
      gaps_on = (ph < RandPhases - 1);  // drop all idling in the closing phase
      case ($urandom_range(0, 7))
        0: begin lo = 0; hi = 12'hFFF; end
        1: begin lo = 0; hi = sample_t'($urandom_range(1, 4095)); end
        2: begin lo = sample_t'($urandom_range(0, 4094)); hi = 12'hFFF; end
        3: begin
          lo = sample_t'($urandom_range(2048, 4095));
          hi = sample_t'($urandom_range(0, lo));
        end
        4: begin
          lo = sample_t'($urandom_range(0, 4000));
          hi = sample_t'(32'(lo) + $urandom_range(1, 40));
        end
        default: begin
          lo = sample_t'($urandom_range(0, 2047));
          hi = sample_t'($urandom_range(32'(lo) + 1, 4095));
        end
      endcase
      write_reg(CfgAxisMin, lo);
      write_reg(CfgAxisMax, hi);
      if ($urandom_range(0, 2) != 0) write_reg(CfgCalEn, CfgDataW'($urandom_range(0, 4095)));
      if (ph == 3) write_reg(CfgSpare, CfgDataW'($urandom_range(0, 4095)));
      @(negedge clk);
      // Once, stall the receiver while a full phase is queued so the block
      // backs up and refuses input.
      if (ph == 2) hold_req = 1'b1;
      for (i = 0; i < PhaseItems; i++) begin
        if (fail_left > 0) begin
          ok = 1'b0;
          fail_left--;
        end else if ($urandom_range(0, 24) == 0) begin
          ok = 1'b0;
          fail_left = $urandom_range(3, 8);
        end else begin
          ok = ($urandom_range(0, 9) != 0);
        end
        poll_q.push_back(mk_poll(ok, pick_axis(lo, hi), pick_axis(lo, hi)));
      end
      wait_idle();
    end

    $display("Run covered %0d good and %0d failed polls, %0d results with slow_poll high,",
             n_good, n_bad, n_slow);
    $display("  %0d rest centers captured and %0d register writes.", n_capture, n_wr);
    if (n_err == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
